@@ rtl/core/lpht_pkg.sv @@
// Shared constants, payload types and controller states for the linear probe hash table.
package lpht_pkg;

  // Table geometry.
  localparam int SLOT_BITS = 10;
  localparam int REF_BITS  = 17;
  localparam int KEY_BITS  = 64;
  localparam int CNT_BITS  = SLOT_BITS + 1;
  localparam int SLOTS     = 1 << SLOT_BITS;

  // Valid bits are kept as rows of slots with one live flag per row in flops.
  localparam int ROW_BITS  = (SLOT_BITS > 10) ? 8 : SLOT_BITS - 2;
  localparam int COL_BITS  = SLOT_BITS - ROW_BITS;
  localparam int ROWS      = 1 << ROW_BITS;
  localparam int COLS      = 1 << COL_BITS;

  // Operation codes.
  localparam logic [1:0] MODE_FIND   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [KEY_BITS-1:0] key;
    logic [REF_BITS-1:0] node_ref;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [REF_BITS-1:0]  found_ref;
    logic [SLOT_BITS-1:0] slot_index;
    logic [CNT_BITS-1:0]  occupancy;
  } out_t;

  // One stored slot.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [REF_BITS-1:0] node_ref;
  } slot_word_t;

  // Registered read result from the slot store.
  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [REF_BITS-1:0] node_ref;
  } slot_rd_t;

  // Write request into the slot store.
  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    logic [KEY_BITS-1:0]  key;
    logic [REF_BITS-1:0]  node_ref;
  } slot_wr_t;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_PROBE,
    CTRL_RESP
  } ctrl_state_t;

endpackage

@@ rtl/core/lpht_store.sv @@
// Slot storage: key and reference memory, row valid memory and per-row live flags.
module lpht_store
  import lpht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SLOT_BITS-1:0] rd_addr,
  output slot_rd_t             rd,
  input  slot_wr_t             wr,
  input  logic                 clear_all
);

  slot_word_t          key_mem [SLOTS];
  logic [COLS-1:0]     vmem    [ROWS];
  logic [ROWS-1:0]     row_live;

  slot_word_t          word_q;
  logic [COLS-1:0]     vrow_q;
  logic                live_q;
  logic [COL_BITS-1:0] col_q;

  logic [ROW_BITS-1:0] rd_row;
  logic [ROW_BITS-1:0] wr_row;
  logic [COL_BITS-1:0] wr_col;
  logic [COLS-1:0]     wr_vrow;

  assign rd_row = rd_addr[SLOT_BITS-1:COL_BITS];
  assign wr_row = wr.addr[SLOT_BITS-1:COL_BITS];
  assign wr_col = wr.addr[COL_BITS-1:0];

  // A write always follows a read of the same slot, so the registered row
  // holds the current valid bits of the row being written. A row that is
  // not live is treated as all empty.
  assign wr_vrow = (live_q ? vrow_q : '0) | ({{(COLS-1){1'b0}}, 1'b1} << wr_col);

  // Registered read port of both memories and the live flag.
  always_ff @(posedge clk) begin
    word_q <= key_mem[rd_addr];
    vrow_q <= vmem[rd_row];
    live_q <= row_live[rd_row];
    col_q  <= rd_addr[COL_BITS-1:0];
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr] <= '{key: wr.key, node_ref: wr.node_ref};
      vmem[wr_row]     <= wr_vrow;
    end
  end

  // Live flags: reset or a clear empties the whole table at once.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_live <= '0;
    end else if (wr.en) begin
      row_live[wr_row] <= 1'b1;
    end
  end

  assign rd.valid    = live_q & vrow_q[col_q];
  assign rd.key      = word_q.key;
  assign rd.node_ref = word_q.node_ref;

endmodule

@@ rtl/core/lpht_ctrl.sv @@
// Probe sequencer with the shared key comparator and slot address incrementer.
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_free,
  output logic                 res_load,
  output out_t                 res,
  output logic [SLOT_BITS-1:0] rd_addr,
  input  slot_rd_t             rd,
  output slot_wr_t             wr,
  output logic                 clear_all
);

  ctrl_state_t          state, state_next;
  logic [1:0]           op_mode, op_mode_next;
  logic [KEY_BITS-1:0]  op_key, op_key_next;
  logic [REF_BITS-1:0]  op_ref, op_ref_next;
  logic [SLOT_BITS-1:0] cur_pos, cur_pos_next;
  logic [SLOT_BITS-1:0] probes, probes_next;
  logic [CNT_BITS-1:0]  filled, filled_next;
  out_t                 res_next;
  logic                 key_match;
  logic                 last_probe;

  // Shared comparator and round detector.
  assign key_match  = (rd.key == op_key);
  assign last_probe = (probes == {SLOT_BITS{1'b1}});

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CTRL_IDLE;
      filled <= '0;
    end else begin
      state  <= state_next;
      filled <= filled_next;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    op_mode <= op_mode_next;
    op_key  <= op_key_next;
    op_ref  <= op_ref_next;
    cur_pos <= cur_pos_next;
    probes  <= probes_next;
    res     <= res_next;
  end

  // Next state, memory requests and result.
  always_comb begin
    state_next   = state;
    op_mode_next = op_mode;
    op_key_next  = op_key;
    op_ref_next  = op_ref;
    cur_pos_next = cur_pos;
    probes_next  = probes;
    filled_next  = filled;
    res_next     = res;
    in_ready     = 1'b0;
    res_load     = 1'b0;
    rd_addr      = cur_pos;
    clear_all    = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = cur_pos;
    wr.key       = op_key;
    wr.node_ref  = op_ref;

    case (state)
      CTRL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.mode)
            MODE_FIND, MODE_INSERT: begin
              op_mode_next = in_data.mode;
              op_key_next  = in_data.key;
              op_ref_next  = in_data.node_ref;
              cur_pos_next = in_data.key[SLOT_BITS-1:0];
              rd_addr      = in_data.key[SLOT_BITS-1:0];
              probes_next  = '0;
              state_next   = CTRL_PROBE;
            end
            MODE_CLEAR: begin
              clear_all   = 1'b1;
              filled_next = '0;
              res_next    = '{status: STAT_OK, found_ref: '0, slot_index: '0,
                              occupancy: '0};
              state_next  = CTRL_RESP;
            end
            default: begin
              res_next   = '{status: STAT_OK, found_ref: '0, slot_index: '0,
                             occupancy: filled};
              state_next = CTRL_RESP;
            end
          endcase
        end
      end

      // One slot is examined per cycle; the next slot is read meanwhile.
      CTRL_PROBE: begin
        if (!rd.valid) begin
          if (op_mode == MODE_INSERT) begin
            wr.en       = 1'b1;
            filled_next = filled + 1'b1;
            res_next    = '{status: STAT_OK, found_ref: '0, slot_index: cur_pos,
                            occupancy: filled + 1'b1};
          end else begin
            res_next = '{status: STAT_MISS, found_ref: '0, slot_index: '0,
                         occupancy: filled};
          end
          state_next = CTRL_RESP;
        end else if (op_mode == MODE_FIND && key_match) begin
          res_next   = '{status: STAT_OK, found_ref: rd.node_ref, slot_index: cur_pos,
                         occupancy: filled};
          state_next = CTRL_RESP;
        end else if (last_probe) begin
          res_next   = '{status: STAT_FULL, found_ref: '0, slot_index: '0,
                         occupancy: filled};
          state_next = CTRL_RESP;
        end else begin
          cur_pos_next = cur_pos + 1'b1;
          rd_addr      = cur_pos + 1'b1;
          probes_next  = probes + 1'b1;
        end
      end

      // Hand the result over once the output register has room.
      CTRL_RESP: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = CTRL_IDLE;
        end
      end

      default: begin
        state_next = CTRL_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// Top level of the linear probe hash table: sequencer, slot store and output register.
//
// Open-addressing hash table of 1024 slots with linear probing, one transaction at a
// time. A find or insert is accepted, probes one slot after another (starting at the
// key's low slot bits and wrapping, at most 1024), and then loads the result into the
// output register once that register has room. A clear or an unused mode goes
// straight to loading its result. The probe rate is set by the single read port of
// the slot memory and the one 64-bit key comparator. Clear empties the table at once
// through per-row live flags, so no clearing pass is needed after reset or after a
// clear. A new transaction is accepted while a finished result still waits in the
// output register.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic                 out_free;
  logic                 res_load;
  out_t                 res;
  logic [SLOT_BITS-1:0] rd_addr;
  slot_rd_t             rd;
  slot_wr_t             wr;
  logic                 clear_all;

  assign out_free = !out_valid || out_ready;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd        (rd),
    .wr        (wr),
    .clear_all (clear_all)
  );

  lpht_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd        (rd),
    .wr        (wr),
    .clear_all (clear_all)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
  end

endmodule
